[rtl/core/cyclic_deadline_monitor_assert.svh]
// assertion macros of the cyclic deadline monitor rtl
`ifndef CYCLIC_DEADLINE_MONITOR_ASSERT_SVH
`define CYCLIC_DEADLINE_MONITOR_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define CDM_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define CDM_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/cdm_pkg.sv]
// types and constants of the cyclic deadline monitor
`default_nettype none

package cdm_pkg;

   localparam int unsigned WAKE_W     = 63;
   localparam int unsigned EXEC_W     = 32;
   localparam int unsigned PERIOD_W   = 32;
   localparam int unsigned OUT_W      = 64;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 63;

   // period / 10 as (period * RECIP10) >> RECIP10_SHIFT, exact for 32-bit periods
   localparam int unsigned  PERIOD_DIVISOR = 10;
   localparam logic [31:0]  RECIP10        = 32'hCCCC_CCCD;
   localparam int unsigned  RECIP10_SHIFT  = 35;
   localparam int unsigned  DIV10_W        = 64 - RECIP10_SHIFT;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000000;
   localparam logic [DIV10_W-1:0]  DIV10_RESET  = DIV10_W'(1000000 / PERIOD_DIVISOR);

   localparam logic [OUT_W-1:0] SIGN64 = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIOD    = 2'd0,
      CSR_THRESHOLD = 2'd1,
      CSR_ORIGIN    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] threshold;   // effective threshold, default already applied
      logic [WAKE_W-1:0]   origin;
   } cfg_type;

   typedef struct packed {
      logic [WAKE_W-1:0] wake;
      logic [EXEC_W-1:0] exec;
      logic              first;
      logic [OUT_W-1:0]  wake_delta;    // wake minus previous wake, two's complement
   } front_type;

   typedef struct packed {
      logic [OUT_W-1:0]   wake_lag;
      logic [OUT_W-1:0]   cycle_jitter;
      logic               error_valid;
      logic               overrun;
      logic               missed_deadline;
      logic [COUNT_W-1:0] cycle_count;
      logic [COUNT_W-1:0] overrun_count;
      logic [COUNT_W-1:0] missed_count;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/cdm_req_if.sv]
// input channel of the cyclic deadline monitor
`default_nettype none

interface cdm_req_if;
   logic                           valid;
   logic                           ready;
   logic [cdm_pkg::WAKE_W-1:0]     wake_time;
   logic [cdm_pkg::EXEC_W-1:0]     exec_time;
   logic                           first_cycle;

   modport source (output valid, output wake_time, output exec_time, output first_cycle,
                   input ready);
   modport sink   (input valid, input wake_time, input exec_time, input first_cycle,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/cdm_rsp_if.sv]
// result channel of the cyclic deadline monitor
`default_nettype none

interface cdm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cdm_pkg::OUT_W-1:0]     wake_lag;
   logic [cdm_pkg::OUT_W-1:0]     cycle_jitter;
   logic                          error_valid;
   logic                          overrun;
   logic                          missed_deadline;
   logic [cdm_pkg::COUNT_W-1:0]   cycle_count;
   logic [cdm_pkg::COUNT_W-1:0]   overrun_count;
   logic [cdm_pkg::COUNT_W-1:0]   missed_count;

   modport source (output valid, output wake_lag, output cycle_jitter,
                   output error_valid, output overrun, output missed_deadline,
                   output cycle_count, output overrun_count, output missed_count,
                   input ready);
   modport sink   (input valid, input wake_lag, input cycle_jitter,
                   input error_valid, input overrun, input missed_deadline,
                   input cycle_count, input overrun_count, input missed_count,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/cdm_csr.sv]
// configuration registers and period/10 threshold default
`default_nettype none

module cdm_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [cdm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cdm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output cdm_pkg::cfg_type                       cfg
);

   logic [cdm_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [cdm_pkg::PERIOD_W-1:0] threshold_ff, threshold_in;
   logic [cdm_pkg::WAKE_W-1:0]   origin_ff, origin_in;
   logic [cdm_pkg::DIV10_W-1:0]  div10_ff, div10_in;
   logic [63:0]                  product;

   // reciprocal multiply straight off the write data, registered with the period
   assign product = 64'(csr_wdata[cdm_pkg::PERIOD_W-1:0]) * 64'(cdm_pkg::RECIP10);

   always_comb begin
      period_in    = period_ff;
      threshold_in = threshold_ff;
      origin_in    = origin_ff;
      div10_in     = div10_ff;
      if (csr_wr_en) begin
         case (cdm_pkg::csr_index_type'(csr_index))
            cdm_pkg::CSR_PERIOD: begin
               period_in = csr_wdata[cdm_pkg::PERIOD_W-1:0];
               div10_in  = product[63:cdm_pkg::RECIP10_SHIFT];
            end
            cdm_pkg::CSR_THRESHOLD: begin
               threshold_in = csr_wdata[cdm_pkg::PERIOD_W-1:0];
            end
            cdm_pkg::CSR_ORIGIN: begin
               origin_in = csr_wdata[cdm_pkg::WAKE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= cdm_pkg::PERIOD_RESET;
         threshold_ff <= '0;
         origin_ff    <= '0;
         div10_ff     <= cdm_pkg::DIV10_RESET;
      end else begin
         period_ff    <= period_in;
         threshold_ff <= threshold_in;
         origin_ff    <= origin_in;
         div10_ff     <= div10_in;
      end
   end

   assign cfg.period    = period_ff;
   assign cfg.threshold = (threshold_ff == '0) ? cdm_pkg::PERIOD_W'(div10_ff) : threshold_ff;
   assign cfg.origin    = origin_ff;

endmodule

`default_nettype wire

[rtl/core/cdm_front.sv]
// input register with wake-to-wake delta
`default_nettype none

module cdm_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic                           advance,
   input  wire logic [cdm_pkg::WAKE_W-1:0]     wake,
   input  wire logic [cdm_pkg::EXEC_W-1:0]     exec,
   input  wire logic                           first,
   input  wire logic [cdm_pkg::WAKE_W-1:0]     last_wake,
   output logic                                valid,
   output cdm_pkg::front_type                  item
);

   logic                  valid_ff, valid_in;
   cdm_pkg::front_type    item_ff, item_in;
   logic [cdm_pkg::WAKE_W-1:0] prev_wake;

   // previous word is still held here if not yet evaluated
   assign prev_wake = valid_ff ? item_ff.wake : last_wake;

   always_comb begin
      item_in            = item_ff;
      item_in.wake       = wake;
      item_in.exec       = exec;
      item_in.first      = first;
      item_in.wake_delta = {1'b0, wake} - {1'b0, prev_wake};
      valid_in = accept ? 1'b1 : (advance ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

`default_nettype wire

[rtl/core/cdm_eval.sv]
// deadline, error, flags and run counters for one word
`default_nettype none

module cdm_eval #(
   parameter int unsigned COUNTER_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire cdm_pkg::front_type             item,
   input  wire cdm_pkg::cfg_type               cfg,
   output cdm_pkg::result_type                 result,
   output logic [cdm_pkg::WAKE_W-1:0]          last_wake
);

   localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

   logic [cdm_pkg::OUT_W-1:0]  next_deadline_ff, next_deadline_in;
   logic [cdm_pkg::WAKE_W-1:0] last_wake_ff, last_wake_in;
   logic [COUNTER_WIDTH-1:0]   cycles_ff, cycles_in;
   logic [COUNTER_WIDTH-1:0]   overruns_ff, overruns_in;
   logic [COUNTER_WIDTH-1:0]   misses_ff, misses_in;

   logic                       start;
   logic [cdm_pkg::OUT_W-1:0]  deadline;
   logic [cdm_pkg::OUT_W:0]    lat_full;
   logic [cdm_pkg::OUT_W:0]    err_full;
   logic [cdm_pkg::OUT_W:0]    deadline_sum;
   logic [33:0]                bound_hi;
   logic [33:0]                bound_lo;
   logic                       over;
   logic                       missed;
   logic [COUNTER_WIDTH-1:0]   over_base;
   logic [COUNTER_WIDTH-1:0]   miss_base;

   always_comb begin
      start    = item.first || (cycles_ff == '0);
      deadline = start ? {1'b0, cfg.origin} : next_deadline_ff;

      // below -2^63 clamps to the most negative value
      lat_full = {2'b00, item.wake} - {1'b0, deadline};
      err_full = {item.wake_delta[cdm_pkg::OUT_W-1], item.wake_delta}
               - {33'b0, cfg.period};

      // |delta - period| > thr  <=>  delta > period + thr  or  delta < period - thr
      bound_hi = {2'b00, cfg.period} + {2'b00, cfg.threshold};
      bound_lo = {2'b00, cfg.period} - {2'b00, cfg.threshold};
      over = !start &&
             (($signed(item.wake_delta) > $signed({30'b0, bound_hi})) ||
              ($signed(item.wake_delta) < $signed({{30{bound_lo[33]}}, bound_lo})));
      missed = item.exec > cfg.period;

      over_base = start ? '0 : overruns_ff;
      miss_base = start ? '0 : misses_ff;
      cycles_in   = start ? CNT_ONE
                          : ((cycles_ff == CNT_MAX) ? cycles_ff : cycles_ff + CNT_ONE);
      overruns_in = (over && (over_base != CNT_MAX)) ? over_base + CNT_ONE : over_base;
      misses_in   = (missed && (miss_base != CNT_MAX)) ? miss_base + CNT_ONE : miss_base;

      deadline_sum     = {1'b0, deadline} + {33'b0, cfg.period};
      next_deadline_in = deadline_sum[cdm_pkg::OUT_W] ? '1
                                                      : deadline_sum[cdm_pkg::OUT_W-1:0];
      last_wake_in     = item.wake;

      result.wake_lag = (lat_full[cdm_pkg::OUT_W] && !lat_full[cdm_pkg::OUT_W-1])
                        ? cdm_pkg::SIGN64 : lat_full[cdm_pkg::OUT_W-1:0];
      if (start) begin
         result.cycle_jitter = '0;
      end else if (err_full[cdm_pkg::OUT_W] && !err_full[cdm_pkg::OUT_W-1]) begin
         result.cycle_jitter = cdm_pkg::SIGN64;
      end else begin
         result.cycle_jitter = err_full[cdm_pkg::OUT_W-1:0];
      end
      result.error_valid     = !start;
      result.overrun         = over;
      result.missed_deadline = missed;
      result.cycle_count     = cdm_pkg::COUNT_W'(cycles_in);
      result.overrun_count   = cdm_pkg::COUNT_W'(overruns_in);
      result.missed_count    = cdm_pkg::COUNT_W'(misses_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_deadline_ff <= '0;
         last_wake_ff     <= '0;
         cycles_ff        <= '0;
         overruns_ff      <= '0;
         misses_ff        <= '0;
      end else if (advance) begin
         next_deadline_ff <= next_deadline_in;
         last_wake_ff     <= last_wake_in;
         cycles_ff        <= cycles_in;
         overruns_ff      <= overruns_in;
         misses_ff        <= misses_in;
      end
   end

   assign last_wake = last_wake_ff;

endmodule

`default_nettype wire

[rtl/core/cyclic_deadline_monitor.sv]
// top level of the cyclic deadline monitor
//
//   port       dir   kind                 contents
//   req_chan   in    valid/ready word     wake_time, exec_time, first_cycle
//   rsp_chan   out   valid/ready word     latency, period error, flags, run counts
//   csr_*      in    write-only regs      period_ns, overrun_threshold_ns, origin_time
//
// one word per clock sustained while rsp takes every result; an accepted word goes
// into the input register, then through the evaluate stage into the result register
// the evaluate stage's state loop (deadline, last wake, counters) updates on every evaluated word
// synchronous active-high reset: deadline, last wake and counters to zero, period to 1 ms
// rsp stall holds the result register; the input register still takes a word while empty
`default_nettype none
`include "cyclic_deadline_monitor_assert.svh"

module cyclic_deadline_monitor #(
   parameter int unsigned COUNTER_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   cdm_req_if.sink                                req_chan,
   cdm_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [cdm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cdm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   cdm_pkg::cfg_type      cfg;
   cdm_pkg::front_type    front_item;
   cdm_pkg::result_type   eval_result;
   logic                  front_valid;
   logic [cdm_pkg::WAKE_W-1:0] last_wake;

   logic                  accept;
   logic                  fire;          // evaluate stage moves a word into the result reg
   logic                  rsp_valid_ff, rsp_valid_in;
   cdm_pkg::result_type   rsp_data_ff;

   // config registers, threshold default resolved here
   cdm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // handshake: result reg free or draining lets the evaluate stage go
   assign fire           = front_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !front_valid || fire;
   assign accept         = req_chan.valid && req_chan.ready;

   // input register, also forms wake minus previous wake
   cdm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .advance   (fire),
      .wake      (req_chan.wake_time),
      .exec      (req_chan.exec_time),
      .first     (req_chan.first_cycle),
      .last_wake (last_wake),
      .valid     (front_valid),
      .item      (front_item)
   );

   // run state and the per-word result
   cdm_eval #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_eval (
      .clock     (clock),
      .reset     (reset),
      .advance   (fire),
      .item      (front_item),
      .cfg       (cfg),
      .result    (eval_result),
      .last_wake (last_wake)
   );

   // result register
   assign rsp_valid_in = fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= eval_result;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.wake_lag        = rsp_data_ff.wake_lag;
   assign rsp_chan.cycle_jitter    = rsp_data_ff.cycle_jitter;
   assign rsp_chan.error_valid     = rsp_data_ff.error_valid;
   assign rsp_chan.overrun         = rsp_data_ff.overrun;
   assign rsp_chan.missed_deadline = rsp_data_ff.missed_deadline;
   assign rsp_chan.cycle_count     = rsp_data_ff.cycle_count;
   assign rsp_chan.overrun_count   = rsp_data_ff.overrun_count;
   assign rsp_chan.missed_count    = rsp_data_ff.missed_count;

   // an evaluated word always shows up on rsp the next cycle
   `CDM_ASSERT_NEXT(a_fire_loads_rsp, fire, rsp_valid_ff, "evaluated word not presented")

   // a run start reports a zero error and no overrun
   `CDM_ASSERT_IMPL(a_start_no_error, rsp_valid_ff && !rsp_data_ff.error_valid,
      !rsp_data_ff.overrun && (rsp_data_ff.cycle_jitter == '0), "error on run start")

   // a first-of-run word restarts the cycle count at one
   `CDM_ASSERT_NEXT(a_first_count_one, fire && front_item.first,
      rsp_data_ff.cycle_count == cdm_pkg::COUNT_W'(1), "run start count not one")

endmodule

`default_nettype wire

[tb/tb.sv]
// self-checking testbench of the cyclic deadline monitor: predicted reports against the block
module tb;

   // run counters of the block under test, kept at the default width
   localparam int unsigned RUN_COUNT_W      = 32;
   localparam int unsigned CYCLE_LIMIT      = 400000;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned MAX_REPORTED     = 10;
   localparam int unsigned RANDOM_PHASES    = 8;
   localparam int unsigned WORDS_PER_PHASE  = 235;
   localparam int unsigned DRAIN_CYCLES     = 8;

   // index with no register behind it, writes there are dropped
   localparam logic [cdm_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic [cdm_pkg::WAKE_W-1:0]   WAKE_MAX   = '1;
   localparam logic [cdm_pkg::EXEC_W-1:0]   EXEC_MAX   = '1;
   localparam logic [cdm_pkg::PERIOD_W-1:0] PERIOD_MAX = '1;

   // one executed task cycle as offered on the request channel
   typedef struct packed {
      logic [cdm_pkg::WAKE_W-1:0] wake_time;
      logic [cdm_pkg::EXEC_W-1:0] exec_time;
      logic                       first_cycle;
   } cycle_word_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [cdm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [cdm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   cdm_req_if req_bus ();
   cdm_rsp_if rsp_bus ();

   cyclic_deadline_monitor #(.COUNTER_WIDTH(RUN_COUNT_W)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // words waiting for the driver, reports waiting for the block
   cycle_word_type       words_to_send[$];
   cdm_pkg::result_type  expected_reports[$];

   int unsigned words_queued       = 0;
   int unsigned words_accepted     = 0;
   int unsigned reports_checked    = 0;
   int unsigned mismatches         = 0;
   int unsigned unexpected_reports = 0;
   int unsigned settings_applied   = 0;
   int unsigned cycle_counter      = 0;

   // idling odds in percent, changed per phase
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // one-cycle pulse that starts a long result hold, counted down by the receiver
   logic        rsp_hold_kick = 1'b0;
   int unsigned hold_left     = 0;

   // register copies as the block should see them
   logic [cdm_pkg::PERIOD_W-1:0] watch_period;
   logic [cdm_pkg::PERIOD_W-1:0] watch_threshold;
   logic [cdm_pkg::WAKE_W-1:0]   watch_origin;

   // run state of the monitored task
   logic [cdm_pkg::OUT_W-1:0]  track_deadline;
   logic [cdm_pkg::WAKE_W-1:0] track_last_wake;
   logic [RUN_COUNT_W-1:0]     track_cycles;
   logic [RUN_COUNT_W-1:0]     track_overruns;
   logic [RUN_COUNT_W-1:0]     track_misses;

   initial forever #1 clock = ~clock;

   always @(posedge clock) cycle_counter <= cycle_counter + 1;

   // watchdog on the whole run
   initial begin : watchdog
      wait (cycle_counter >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d reports still due",
               cycle_counter, expected_reports.size());
      $display("status: fail");
      $finish;
   end

   // two's complement of a magnitude, clamped at the most negative value
   function automatic logic [cdm_pkg::OUT_W-1:0] negate_saturated(
         logic [cdm_pkg::OUT_W-1:0] mag);
      return (mag >= cdm_pkg::SIGN64) ? cdm_pkg::SIGN64 : (64'd0 - mag);
   endfunction

   function automatic logic [RUN_COUNT_W-1:0] bump_saturating(logic [RUN_COUNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // expected report of one accepted word, advances the run state
   function automatic cdm_pkg::result_type predict_cycle_report(cycle_word_type w);
      cdm_pkg::result_type       r;
      logic [cdm_pkg::OUT_W-1:0] wake;
      logic [cdm_pkg::OUT_W-1:0] deadline;
      logic [cdm_pkg::OUT_W-1:0] period;
      logic [cdm_pkg::OUT_W-1:0] gap;
      logic [cdm_pkg::OUT_W-1:0] mag;
      logic [cdm_pkg::OUT_W-1:0] limit;
      logic                      run_start;
      r         = '0;
      mag       = '0;
      wake      = {1'b0, w.wake_time};
      period    = {32'b0, watch_period};
      // a run also starts when nothing has been seen since reset
      run_start = w.first_cycle || (track_cycles == '0);
      if (run_start) begin
         deadline       = {1'b0, watch_origin};
         track_cycles   = '0;
         track_overruns = '0;
         track_misses   = '0;
      end else begin
         deadline = track_deadline;
      end
      r.wake_lag    = (wake >= deadline) ? wake - deadline : negate_saturated(deadline - wake);
      r.error_valid = !run_start;
      if (!run_start) begin
         if (wake >= {1'b0, track_last_wake}) begin
            gap = wake - {1'b0, track_last_wake};
            if (gap >= period) begin
               mag            = gap - period;
               r.cycle_jitter = mag;
            end else begin
               mag            = period - gap;
               r.cycle_jitter = negate_saturated(mag);
            end
         end else begin
            // wake went backwards, error is always negative here
            mag            = {1'b0, track_last_wake} - wake + period;
            r.cycle_jitter = negate_saturated(mag);
         end
         // zero threshold selects a tenth of the period
         limit     = (watch_threshold == '0) ? period / cdm_pkg::PERIOD_DIVISOR
                                              : {32'b0, watch_threshold};
         r.overrun = mag > limit;
      end
      r.missed_deadline = w.exec_time > watch_period;
      track_cycles = bump_saturating(track_cycles);
      if (r.overrun) track_overruns = bump_saturating(track_overruns);
      if (r.missed_deadline) track_misses = bump_saturating(track_misses);
      track_last_wake = w.wake_time;
      // deadline sticks at all ones instead of wrapping
      track_deadline  = (deadline > ~period) ? '1 : deadline + period;
      r.cycle_count   = cdm_pkg::COUNT_W'(track_cycles);
      r.overrun_count = cdm_pkg::COUNT_W'(track_overruns);
      r.missed_count  = cdm_pkg::COUNT_W'(track_misses);
      return r;
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTED)
            $display("report %0d, %s: expected %h, got %h", reports_checked, name, want, got);
      end
   endtask

   // driver: offers queued words, predicts every word the block takes
   always @(posedge clock) begin : drive_words
      cycle_word_type offered;
      cycle_word_type next_word;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            offered.wake_time   = req_bus.wake_time;
            offered.exec_time   = req_bus.exec_time;
            offered.first_cycle = req_bus.first_cycle;
            expected_reports.push_back(predict_cycle_report(offered));
            words_accepted++;
         end
         // a held word stays put until it is taken
         if (!req_bus.valid || req_bus.ready) begin
            if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word           = words_to_send.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.wake_time   <= next_word.wake_time;
               req_bus.exec_time   <= next_word.exec_time;
               req_bus.first_cycle <= next_word.first_cycle;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks every taken report against the oldest prediction
   always @(posedge clock) begin : check_reports
      cdm_pkg::result_type seen;
      cdm_pkg::result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.wake_lag        = rsp_bus.wake_lag;
            seen.cycle_jitter    = rsp_bus.cycle_jitter;
            seen.error_valid     = rsp_bus.error_valid;
            seen.overrun         = rsp_bus.overrun;
            seen.missed_deadline = rsp_bus.missed_deadline;
            seen.cycle_count     = rsp_bus.cycle_count;
            seen.overrun_count   = rsp_bus.overrun_count;
            seen.missed_count    = rsp_bus.missed_count;
            reports_checked++;
            if (expected_reports.size() == 0) begin
               unexpected_reports++;
               if (unexpected_reports <= MAX_REPORTED)
                  $display("report %0d arrived with no word behind it", reports_checked);
            end else begin
               want = expected_reports.pop_front();
               compare_field("wake_lag", want.wake_lag, seen.wake_lag);
               compare_field("cycle_jitter", want.cycle_jitter, seen.cycle_jitter);
               compare_field("error_valid", want.error_valid, seen.error_valid);
               compare_field("overrun", want.overrun, seen.overrun);
               compare_field("missed_deadline", want.missed_deadline, seen.missed_deadline);
               compare_field("cycle_count", want.cycle_count, seen.cycle_count);
               compare_field("overrun_count", want.overrun_count, seen.overrun_count);
               compare_field("missed_count", want.missed_count, seen.missed_count);
            end
         end
         // long hold first, otherwise random stalls
         if (rsp_hold_kick) begin
            hold_left     <= LONG_HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic queue_word(logic [cdm_pkg::WAKE_W-1:0] wake,
                             logic [cdm_pkg::EXEC_W-1:0] exec, logic first);
      cycle_word_type w;
      w.wake_time   = wake;
      w.exec_time   = exec;
      w.first_cycle = first;
      words_to_send.push_back(w);
      words_queued++;
   endtask

   // every word taken and every report back
   task automatic wait_until_drained();
      while (words_accepted != words_queued || expected_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
      @(posedge clock);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   task automatic write_register(logic [cdm_pkg::CSR_IDX_W-1:0] idx,
                                 logic [cdm_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         cdm_pkg::CSR_PERIOD:    watch_period    = value[cdm_pkg::PERIOD_W-1:0];
         cdm_pkg::CSR_THRESHOLD: watch_threshold = value[cdm_pkg::PERIOD_W-1:0];
         cdm_pkg::CSR_ORIGIN:    watch_origin    = value[cdm_pkg::WAKE_W-1:0];
         default: ;
      endcase
   endtask

   // all three registers, junk above the 32-bit ones must be ignored
   task automatic program_settings(logic [cdm_pkg::PERIOD_W-1:0] period,
                                   logic [cdm_pkg::PERIOD_W-1:0] threshold,
                                   logic [cdm_pkg::WAKE_W-1:0] origin);
      write_register(cdm_pkg::CSR_PERIOD, {31'($urandom), period});
      write_register(cdm_pkg::CSR_THRESHOLD, {31'($urandom), threshold});
      write_register(cdm_pkg::CSR_ORIGIN, origin);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_applied++;
   endtask

   // one register setting, mostly well-formed runs with jitter around the threshold
   task automatic run_random_phase(int unsigned phase_no);
      cycle_word_type    batch[$];
      cycle_word_type    w;
      logic [31:0]       period;
      logic [31:0]       threshold;
      logic [31:0]       thr_eff;
      logic [62:0]       origin;
      longint unsigned   wake_run;
      longint unsigned   span;
      longint unsigned   exec_pick;
      longint            jit;
      int unsigned       run_len;
      case ($urandom_range(3))
         0: period = $urandom_range(1, 200);
         1: period = $urandom_range(1000, 2000000);
         2: period = $urandom;
         default: period = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(1, 20);
      endcase
      case ($urandom_range(3))
         0, 1: threshold = 32'd0;
         2: threshold = $urandom_range(1, period / 5 + 1);
         default: threshold = $urandom;
      endcase
      origin = ($urandom_range(2) == 0) ? 63'({$urandom, $urandom})
                                         : 63'($urandom_range(0, 1000000));
      thr_eff = (threshold == 0) ? period / cdm_pkg::PERIOD_DIVISOR : threshold;
      span = 2 * longint'(thr_eff) + 3;
      wake_run = origin;

      case (phase_no % 4)
         0: set_idling(0, 0);
         1: set_idling(85, 0);
         2: set_idling(0, 85);
         default: set_idling(27, 27);
      endcase
      program_settings(period, threshold, origin);

      while (batch.size() < WORDS_PER_PHASE) begin
         if ($urandom_range(9) == 0) begin
            // noise: any wake, any exec, any flag
            w.wake_time   = 63'({$urandom, $urandom});
            w.exec_time   = $urandom;
            w.first_cycle = 1'($urandom_range(1));
            batch.push_back(w);
         end else begin
            run_len = $urandom_range(1, 40);
            for (int k = 0; k < run_len && batch.size() < WORDS_PER_PHASE; k++) begin
               jit = longint'({$urandom, $urandom} % span) - longint'(span / 2);
               if (k == 0) wake_run = longint'(origin) + jit;
               else wake_run = wake_run + period + jit;
               case ($urandom_range(3))
                  0: begin
                     exec_pick = longint'(period) + $urandom_range(4);
                     exec_pick = (exec_pick < 2) ? 0 : exec_pick - 2;
                     if (exec_pick > 64'hFFFF_FFFF) exec_pick = 64'hFFFF_FFFF;
                  end
                  1: exec_pick = $urandom_range(0, period);
                  2: exec_pick = $urandom;
                  default: exec_pick = 0;
               endcase
               w.wake_time   = wake_run[62:0];
               w.exec_time   = exec_pick[31:0];
               // a run now and then continues from the previous setting
               w.first_cycle = (k == 0) && ($urandom_range(7) != 0);
               batch.push_back(w);
            end
         end
      end

      // first half, then a pause until every report is back, then the rest
      for (int i = 0; i < batch.size() / 2; i++)
         queue_word(batch[i].wake_time, batch[i].exec_time, batch[i].first_cycle);
      if (phase_no == 0) begin
         // receiver holds off while the sender keeps pushing, the block backs up
         @(posedge clock);
         rsp_hold_kick <= 1'b1;
         @(posedge clock);
         rsp_hold_kick <= 1'b0;
      end
      wait_until_drained();
      for (int i = batch.size() / 2; i < batch.size(); i++)
         queue_word(batch[i].wake_time, batch[i].exec_time, batch[i].first_cycle);
      wait_until_drained();
   endtask

   initial begin : stimulus
      // reset values of the registers and the run state
      watch_period    = cdm_pkg::PERIOD_RESET;
      watch_threshold = '0;
      watch_origin    = '0;
      track_deadline  = '0;
      track_last_wake = '0;
      track_cycles    = '0;
      track_overruns  = '0;
      track_misses    = '0;

      req_bus.valid       = 1'b0;
      req_bus.wake_time   = '0;
      req_bus.exec_time   = '0;
      req_bus.first_cycle = 1'b0;
      rsp_bus.ready       = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 1 ms period, default threshold of a tenth, origin zero
      queue_word('0, '0, 1'b0);                       // run starts with nothing seen yet
      queue_word(63'd1000000, 32'd1000000, 1'b0);     // on time, exec equal to period
      queue_word(63'd2100001, 32'd1000001, 1'b0);     // just over threshold, missed
      queue_word(63'd3200001, '0, 1'b0);              // error exactly at threshold
      queue_word(63'd3200001, '0, 1'b0);              // no gap, error of minus a period
      queue_word(63'd1000, '0, 1'b0);                 // wake goes backwards
      queue_word(WAKE_MAX, EXEC_MAX, 1'b0);           // largest wake and exec
      queue_word('0, '0, 1'b0);                       // error clamps at most negative
      queue_word(63'd5000, 32'd7, 1'b1);              // new run mid-stream
      queue_word(63'd1005000, '0, 1'b0);
      wait_until_drained();

      // zero period: deadline frozen, zero threshold, any nonzero exec is a miss
      write_register(CSR_UNUSED, 63'({$urandom, $urandom}));
      program_settings('0, '0, 63'd1000);
      queue_word(63'd500, '0, 1'b1);                  // wake before the deadline
      queue_word(63'd500, 32'd1, 1'b0);
      queue_word(63'd501, '0, 1'b0);
      wait_until_drained();

      // every register at its top value
      program_settings(PERIOD_MAX, PERIOD_MAX, WAKE_MAX);
      queue_word('0, EXEC_MAX, 1'b1);                 // latency of minus the largest wake
      queue_word(WAKE_MAX, '0, 1'b0);                 // deadline past the wake range
      queue_word('0, '0, 1'b0);
      queue_word(WAKE_MAX, EXEC_MAX, 1'b0);
      wait_until_drained();

      // tightest explicit threshold
      program_settings(32'd1, 32'd1, '0);
      queue_word(63'd10, '0, 1'b1);
      queue_word(63'd11, 32'd1, 1'b0);
      queue_word(63'd13, 32'd2, 1'b0);
      queue_word(63'd16, '0, 1'b0);
      wait_until_drained();

      for (int p = 0; p < RANDOM_PHASES; p++)
         run_random_phase(p);

      // room for any stray report after the last one due
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d cycle words over %0d register settings, with sender gaps,",
               words_accepted, settings_applied);
      $display("result stalls and a long result hold; %0d reports checked, %0d mismatches",
               reports_checked, mismatches + unexpected_reports + expected_reports.size());
      if (mismatches == 0 && unexpected_reports == 0 && expected_reports.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
